// ----- hdl/pva_pkg.sv -----
// ============================================================================
// pva_pkg
// Shared types and constants for the polyphonic voice allocator.
// ============================================================================
package pva_pkg;

    localparam int PVA_NUM_VOICES       = 24;
    localparam int PVA_NUM_NOTES        = 128;
    localparam int PVA_VOICES_PER_BOARD = 8;
    localparam int PVA_QUEUE_DEPTH      = 2;
    localparam int PVA_VOICE_EXT_W      = 8;

    localparam int PVA_NOTE_W   = 7;
    localparam int PVA_VEL_W    = 7;
    localparam int PVA_ACTION_W = 2;
    localparam int PVA_BOARD_W  = 4;
    localparam int PVA_SLOT_W   = 2;
    localparam int PVA_VOICE_W  = 5;
    localparam int PVA_COUNT_W  = 5;

    typedef enum logic [PVA_ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_NONE  = 2'd2
    } pva_action_t;

    typedef enum logic {
        PVA_IDLE,
        PVA_EXEC
    } pva_state_t;

    // One classified note event, as held in the queue between front and back
    typedef struct packed {
        logic [PVA_NOTE_W-1:0] note;
        logic [PVA_VEL_W-1:0]  velocity;
        logic                  is_on;
    } pva_item_t;

endpackage

// ----- hdl/pva_note_if.sv -----
// ============================================================================
// pva_note_if
// Valid/ready channel carrying one note event.
// ============================================================================
interface pva_note_if;
    import pva_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PVA_NOTE_W-1:0] note;
    logic [PVA_VEL_W-1:0]  velocity;

    modport source (output valid, output note, output velocity, input ready);
    modport sink   (input valid, input note, input velocity, output ready);
endinterface

// ----- hdl/pva_cmd_if.sv -----
// ============================================================================
// pva_cmd_if
// Valid/ready channel carrying one voice command.
// ============================================================================
interface pva_cmd_if;
    import pva_pkg::*;

    logic                   valid;
    logic                   ready;
    pva_action_t            action;
    logic [PVA_BOARD_W-1:0] board;
    logic [PVA_SLOT_W-1:0]  slot;
    logic [PVA_VOICE_W-1:0] voice;
    logic [PVA_NOTE_W-1:0]  note_out;
    logic [PVA_VEL_W-1:0]   volume;
    logic [PVA_COUNT_W-1:0] voices_in_use;

    modport source (output valid, output action, output board, output slot, output voice,
                    output note_out, output volume, output voices_in_use, input ready);
    modport sink   (input valid, input action, input board, input slot, input voice,
                    input note_out, input volume, input voices_in_use, output ready);
endinterface

// ----- hdl/pva_front.sv -----
// ============================================================================
// pva_front
// Accepts note events, tags note-on/note-off and queues them for the back end.
// ============================================================================
module pva_front (
    input  logic               clk,
    input  logic               rst_n,
    pva_note_if.sink           note_in,
    output pva_pkg::pva_item_t item,
    output logic               item_valid,
    input  logic               item_pop
);
    import pva_pkg::*;

    localparam int QAW = (PVA_QUEUE_DEPTH > 1) ? $clog2(PVA_QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(PVA_QUEUE_DEPTH + 1);

    pva_item_t          q_mem [PVA_QUEUE_DEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]     count_reg, count_next;
    logic               push;
    logic               pop;
    pva_item_t          in_item;

    assign note_in.ready = (count_reg != QCW'(PVA_QUEUE_DEPTH));
    assign push          = note_in.valid && note_in.ready;
    assign pop           = item_pop && (count_reg != '0);
    assign item_valid    = (count_reg != '0);
    assign item          = q_mem[rd_ptr_reg];

    // classify: any nonzero velocity is a note-on
    always_comb
    begin
        in_item.note     = note_in.note;
        in_item.velocity = note_in.velocity;
        in_item.is_on    = (note_in.velocity != '0);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(PVA_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(PVA_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/pva_back.sv -----
// ============================================================================
// pva_back
// Reads the note map and free ring, then allocates or releases a voice and
// registers the resulting command.
// ============================================================================
module pva_back #(
    parameter int NUM_VOICES = pva_pkg::PVA_NUM_VOICES,
    parameter int NUM_NOTES  = pva_pkg::PVA_NUM_NOTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pva_pkg::pva_item_t item,
    input  logic               item_valid,
    output logic               item_pop,
    pva_cmd_if.source          cmd_out
);
    import pva_pkg::*;

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW = $clog2(NUM_VOICES + 1);
    localparam int NW = $clog2(NUM_NOTES);

    function automatic logic [VW-1:0] ring_next(input logic [VW-1:0] pos);
        return (pos == VW'(NUM_VOICES - 1)) ? '0 : pos + 1'b1;
    endfunction

    // storage
    logic [VW-1:0]         ring_mem [NUM_VOICES];
    logic [NUM_VOICES-1:0] ring_written_reg;
    logic [VW-1:0]         map_mem [NUM_NOTES];
    logic [NUM_NOTES-1:0]  map_valid_reg;

    // control state
    pva_state_t            state_reg, state_next;
    logic [VW-1:0]         head_reg, tail_reg;
    logic [CW-1:0]         free_reg;
    logic                  out_valid_reg;

    // captured item and read data
    pva_item_t             item_reg;
    logic [VW-1:0]         ring_rd_reg;
    logic [VW-1:0]         map_rd_reg;
    logic                  ring_init_reg;
    logic                  hit_reg;

    // output payload
    pva_action_t            action_reg;
    logic [PVA_BOARD_W-1:0] board_reg;
    logic [PVA_SLOT_W-1:0]  slot_reg;
    logic [PVA_VOICE_W-1:0] voice_reg;
    logic [PVA_NOTE_W-1:0]  note_out_reg;
    logic [PVA_VEL_W-1:0]   volume_reg;
    logic [PVA_COUNT_W-1:0] in_use_reg;

    logic                  issue;
    logic                  exec_fire;
    logic [NW-1:0]         rd_idx;
    logic [NW-1:0]         ex_idx;
    logic [VW-1:0]         ring_val;

    pva_action_t           res_action;
    logic [VW-1:0]         res_voice;
    logic                  res_show;
    logic [VW-1:0]         head_next, tail_next;
    logic [CW-1:0]         free_next;
    logic                  upd_map_set, upd_map_clr, upd_ring_we;
    logic [PVA_VOICE_EXT_W-1:0] v_ext;
    logic [CW-1:0]         in_use;

    assign rd_idx   = NW'(item.note);
    assign ex_idx   = NW'(item_reg.note);
    assign ring_val = ring_init_reg ? tail_reg : ring_rd_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            PVA_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = PVA_EXEC;
                end
            end
            PVA_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = PVA_IDLE;
                end
            end
            default:
            begin
                state_next = PVA_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        issue     = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            PVA_IDLE:
            begin
                issue = item_valid;
            end
            PVA_EXEC:
            begin
                exec_fire = !out_valid_reg || cmd_out.ready;
            end
            default:
            begin
                issue     = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    assign item_pop = issue;

    // allocate or release
    always_comb
    begin
        res_action  = ACT_NONE;
        res_voice   = '0;
        res_show    = 1'b0;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        upd_map_set = 1'b0;
        upd_map_clr = 1'b0;
        upd_ring_we = 1'b0;
        if (item_reg.is_on)
        begin
            if (free_reg != '0)
            begin
                res_action  = ACT_START;
                res_voice   = ring_val;
                res_show    = 1'b1;
                tail_next   = ring_next(tail_reg);
                free_next   = free_reg - 1'b1;
                upd_map_set = 1'b1;
            end
        end
        else if (hit_reg)
        begin
            res_action  = ACT_STOP;
            res_voice   = map_rd_reg;
            res_show    = 1'b1;
            upd_map_clr = 1'b1;
            // a full ring drops the returned voice
            if (free_reg < CW'(NUM_VOICES))
            begin
                upd_ring_we = 1'b1;
                head_next   = ring_next(head_reg);
                free_next   = free_reg + 1'b1;
            end
        end
    end

    assign v_ext  = PVA_VOICE_EXT_W'(res_voice);
    assign in_use = CW'(NUM_VOICES) - free_next;

    // memories
    always_ff @(posedge clk)
    begin
        if (exec_fire && upd_ring_we)
        begin
            ring_mem[head_reg] <= res_voice;
        end
        if (issue)
        begin
            ring_rd_reg <= ring_mem[tail_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire && upd_map_set)
        begin
            map_mem[ex_idx] <= res_voice;
        end
        if (issue)
        begin
            map_rd_reg <= map_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            item_reg      <= item;
            hit_reg       <= map_valid_reg[rd_idx];
            ring_init_reg <= !ring_written_reg[tail_reg];
        end
        if (exec_fire)
        begin
            action_reg   <= res_action;
            board_reg    <= res_show ? PVA_BOARD_W'(v_ext % PVA_VOICES_PER_BOARD + 1'b1) : '0;
            slot_reg     <= res_show ? PVA_SLOT_W'(v_ext / PVA_VOICES_PER_BOARD) : '0;
            voice_reg    <= res_show ? PVA_VOICE_W'(v_ext) : '0;
            note_out_reg <= res_show ? item_reg.note : '0;
            volume_reg   <= (res_show && item_reg.is_on) ? item_reg.velocity : '0;
            in_use_reg   <= PVA_COUNT_W'(in_use);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= PVA_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            free_reg         <= CW'(NUM_VOICES);
            out_valid_reg    <= 1'b0;
            map_valid_reg    <= '0;
            ring_written_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                free_reg <= free_next;
                if (upd_map_set)
                begin
                    map_valid_reg[ex_idx] <= 1'b1;
                end
                else if (upd_map_clr)
                begin
                    map_valid_reg[ex_idx] <= 1'b0;
                end
                if (upd_ring_we)
                begin
                    ring_written_reg[head_reg] <= 1'b1;
                end
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cmd_out.valid         = out_valid_reg;
    assign cmd_out.action        = action_reg;
    assign cmd_out.board         = board_reg;
    assign cmd_out.slot          = slot_reg;
    assign cmd_out.voice         = voice_reg;
    assign cmd_out.note_out      = note_out_reg;
    assign cmd_out.volume        = volume_reg;
    assign cmd_out.voices_in_use = in_use_reg;

endmodule

// ----- hdl/polyphonic_voice_allocator.sv -----
// ============================================================================
// polyphonic_voice_allocator
// Assigns synth voices to MIDI notes from a first-in first-out free list.
// ============================================================================
// Usage:
//   note_in  (sink)   : one transaction per MIDI note event (note, velocity).
//                       Nonzero velocity starts a note, zero velocity stops it.
//   cmd_out  (source) : exactly one command transaction per note event, in
//                       order: start, stop or nothing done, with board, slot,
//                       voice, echoed note, volume and the voices in use.
// Path: an accepted note transaction passes the queue, the map/ring read and
//   the update into the output register, where the command becomes valid.
// Back end: it reads the note map and free ring, then writes them back, and
//   takes no new event until that write is done.
// The front end queues up to two events, so note_in keeps accepting while
//   the back end works or a command waits in the output register.
// Reset: the free ring holds voices 0 .. NUM_VOICES-1 in order, every note is
//   unassigned, the queue is empty and no command is valid.
// Receiver stall: the command register holds its transaction, the back end
//   holds in its update step, the queue fills and note_in.ready drops.
// ============================================================================
module polyphonic_voice_allocator #(
    parameter int NUM_VOICES = pva_pkg::PVA_NUM_VOICES,
    parameter int NUM_NOTES  = pva_pkg::PVA_NUM_NOTES
) (
    input  logic      clk,
    input  logic      rst_n,
    pva_note_if.sink  note_in,
    pva_cmd_if.source cmd_out
);
    import pva_pkg::*;

    // classified event handed from front to back
    pva_item_t item;
    logic      item_valid;
    logic      item_pop;

    // front: accept and classify, hold in a short queue
    pva_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .note_in    (note_in),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    // back: allocate or release a voice, drive the command register
    pva_back #(
        .NUM_VOICES (NUM_VOICES),
        .NUM_NOTES  (NUM_NOTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .cmd_out    (cmd_out)
    );

endmodule

// ----- hdl/pva_checker.sv -----
// ============================================================================
// pva_checker
// Port-level checks on the voice command stream of the allocator.
// ============================================================================
module pva_checker #(
    parameter int NUM_VOICES = pva_pkg::PVA_NUM_VOICES
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input pva_pkg::pva_action_t             action,
    input logic [pva_pkg::PVA_BOARD_W-1:0]  board,
    input logic [pva_pkg::PVA_SLOT_W-1:0]   slot,
    input logic [pva_pkg::PVA_VOICE_W-1:0]  voice,
    input logic [pva_pkg::PVA_NOTE_W-1:0]   note_out,
    input logic [pva_pkg::PVA_VEL_W-1:0]    volume,
    input logic [pva_pkg::PVA_COUNT_W-1:0]  voices_in_use
);
    import pva_pkg::*;

    // hold a stalled command
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(voice)
            && $stable(note_out) && $stable(volume) && $stable(voices_in_use))
        else $error("stalled command changed");

    // a started voice has a volume and a consistent board and slot
    a_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_START |-> volume != '0
            && board == {1'b0, voice[2:0]} + 4'd1 && slot == voice[4:3])
        else $error("start command fields inconsistent");

    // a stop carries zero volume and a consistent board and slot
    a_stop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_STOP |-> volume == '0
            && board == {1'b0, voice[2:0]} + 4'd1 && slot == voice[4:3])
        else $error("stop command fields inconsistent");

    // a command that did nothing shows no voice fields
    a_none_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_NONE |-> board == '0 && slot == '0 && voice == '0
            && note_out == '0 && volume == '0)
        else $error("empty command carries data");

    // never more voices in use than exist (checked only for up to 31 voices)
    a_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (NUM_VOICES > 31) || (voices_in_use <= NUM_VOICES))
        else $error("voices in use exceeds voice count");

endmodule

bind polyphonic_voice_allocator pva_checker #(
    .NUM_VOICES (NUM_VOICES)
) u_pva_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (cmd_out.valid),
    .out_ready     (cmd_out.ready),
    .action        (cmd_out.action),
    .board         (cmd_out.board),
    .slot          (cmd_out.slot),
    .voice         (cmd_out.voice),
    .note_out      (cmd_out.note_out),
    .volume        (cmd_out.volume),
    .voices_in_use (cmd_out.voices_in_use)
);
